@@ hdl/fcpa_pkg.sv @@
// ----------------------------------------------------------------------------
// fcpa_pkg
// shared widths, codes and controller/datapath interface types for the
// fixed chunk pool allocator
// ----------------------------------------------------------------------------
package fcpa_pkg;

   localparam int ACTION_W = 2;
   localparam int INDEX_W  = 10;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 11;

   localparam logic [COUNT_W-1:0] POOL_SIZE_RESET = 11'd1024;

   localparam logic [ACTION_W-1:0] ACT_ALLOC    = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_FREE     = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_FREE_ALL = 2'd2;

   localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_NULL  = 2'd3;

   typedef enum logic [1:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_EXEC
   } fsm_state_type;

   typedef struct packed {
      logic accept;
      logic csr_write;
      logic sweep_start;
      logic sweep_step;
      logic sweep_finish;
      logic commit;
   } dp_cmd_type;

   typedef struct packed {
      logic sweep_done;
   } dp_stat_type;

endpackage

@@ hdl/fixed_chunk_pool_allocator.sv @@
// ----------------------------------------------------------------------------
// fixed_chunk_pool_allocator
// pool of equal chunks handed out from a lifo free list
//
// req channel: one transfer per request (allocate, free one chunk, free all).
// rsp channel: one transfer per request, in order: status, granted index and
//   the in-use count after the request.
// csr channel: writes the chunk count and rebuilds the free list.
// allocate and free register the link memory read at the request transfer
//   and commit their result once the output register is free; no new request
//   is taken until the commit.
// free all and a csr write walk the link memory one entry per cycle over the
//   effective chunk count, then free all commits its result.
// the next request is taken once the previous one has committed, so a result
//   may wait in the output register while the next request is at work.
// a request that finishes while the output register is full waits until the
//   receiver takes the pending result.
// after reset the list is built for 1024 chunks (at most MAX_CHUNKS): no
//   request or csr write is taken until that rebuild is done.
// ----------------------------------------------------------------------------
module fixed_chunk_pool_allocator #(
   parameter int MAX_CHUNKS = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [fcpa_pkg::ACTION_W-1:0] req_action,
   input  logic [fcpa_pkg::INDEX_W-1:0]  req_chunk_index,
   input  logic                          req_is_null,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [fcpa_pkg::STATUS_W-1:0] rsp_status,
   output logic [fcpa_pkg::INDEX_W-1:0]  rsp_granted_index,
   output logic [fcpa_pkg::COUNT_W-1:0]  rsp_in_use,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [fcpa_pkg::COUNT_W-1:0]  csr_pool_size
);
   import fcpa_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   fcpa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_action (req_action),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .cmd        (cmd),
      .stat       (stat)
   );

   fcpa_dpath #(
      .MAX_CHUNKS (MAX_CHUNKS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_action        (req_action),
      .req_chunk_index   (req_chunk_index),
      .req_is_null       (req_is_null),
      .csr_pool_size     (csr_pool_size),
      .rsp_status        (rsp_status),
      .rsp_granted_index (rsp_granted_index),
      .rsp_in_use        (rsp_in_use)
   );

endmodule

@@ hdl/fcpa_ctrl.sv @@
// ----------------------------------------------------------------------------
// fcpa_ctrl
// controller: handshakes, list rebuild sequencing and result commit
// ----------------------------------------------------------------------------
module fcpa_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [fcpa_pkg::ACTION_W-1:0] req_action,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output fcpa_pkg::dp_cmd_type          cmd,
   input  fcpa_pkg::dp_stat_type         stat
);
   import fcpa_pkg::*;

   fsm_state_type state_ff, state_in;
   logic          pend_ff, pend_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      pend_in   = pend_ff;
      cmd       = '0;
      req_ready = 1'b0;
      csr_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            csr_ready = 1'b1;
            req_ready = !csr_valid;
            if (csr_valid) begin
               cmd.csr_write   = 1'b1;
               cmd.sweep_start = 1'b1;
               state_in        = ST_SWEEP;
            end else if (req_valid) begin
               cmd.accept = 1'b1;
               if (req_action == ACT_FREE_ALL) begin
                  cmd.sweep_start = 1'b1;
                  pend_in         = 1'b1;
                  state_in        = ST_SWEEP;
               end else begin
                  state_in = ST_EXEC;
               end
            end
         end
         ST_SWEEP: begin
            if (stat.sweep_done) begin
               cmd.sweep_finish = 1'b1;
               pend_in          = 1'b0;
               state_in         = pend_ff ? ST_EXEC : ST_IDLE;
            end else begin
               cmd.sweep_step = 1'b1;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.commit || (rsp_valid_ff && !rsp_ready);

endmodule

@@ hdl/fcpa_dpath.sv @@
// ----------------------------------------------------------------------------
// fcpa_dpath
// datapath: link memory, head and count registers, chunk count register,
// rebuild counter and result registers
// ----------------------------------------------------------------------------
module fcpa_dpath #(
   parameter int MAX_CHUNKS = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  fcpa_pkg::dp_cmd_type          cmd,
   output fcpa_pkg::dp_stat_type         stat,
   input  logic [fcpa_pkg::ACTION_W-1:0] req_action,
   input  logic [fcpa_pkg::INDEX_W-1:0]  req_chunk_index,
   input  logic                          req_is_null,
   input  logic [fcpa_pkg::COUNT_W-1:0]  csr_pool_size,
   output logic [fcpa_pkg::STATUS_W-1:0] rsp_status,
   output logic [fcpa_pkg::INDEX_W-1:0]  rsp_granted_index,
   output logic [fcpa_pkg::COUNT_W-1:0]  rsp_in_use
);
   import fcpa_pkg::*;

   localparam int IW = $clog2(MAX_CHUNKS);
   localparam int LW = $clog2(MAX_CHUNKS + 1);
   localparam int EW = (LW > COUNT_W) ? LW : COUNT_W;
   localparam logic [LW-1:0] NIL = LW'(MAX_CHUNKS);
   localparam logic [EW-1:0] MAX_EXT = EW'(MAX_CHUNKS);

   logic [LW-1:0] mem [MAX_CHUNKS];

   logic [COUNT_W-1:0]  pool_size_ff;
   logic [LW-1:0]       head_ff, head_in;
   logic [LW-1:0]       used_ff, used_in;
   logic [LW-1:0]       sweep_ff;
   logic [LW-1:0]       rd_data_ff;
   logic [ACTION_W-1:0] action_ff;
   logic [INDEX_W-1:0]  index_ff;
   logic                null_ff;

   logic [STATUS_W-1:0] status_ff, status_in;
   logic [INDEX_W-1:0]  granted_ff, granted_in;
   logic [COUNT_W-1:0]  in_use_ff;

   logic [EW-1:0] count_ext, eff_ext, index_ext;
   logic [LW-1:0] eff;
   logic          mem_we;
   logic [IW-1:0] mem_wa;
   logic [LW-1:0] mem_wd;
   logic          push;

   assign count_ext = EW'(pool_size_ff);
   assign eff_ext   = (count_ext > MAX_EXT) ? MAX_EXT : count_ext;
   assign eff       = LW'(eff_ext);
   assign index_ext = EW'(index_ff);

   assign stat.sweep_done = (sweep_ff == eff);

   // result of the held item and its effect on head and count
   always_comb begin
      status_in  = STAT_OK;
      granted_in = '0;
      head_in    = head_ff;
      used_in    = used_ff;
      push       = 1'b0;
      case (action_ff)
         ACT_ALLOC: begin
            if (head_ff == NIL) begin
               status_in = STAT_EMPTY;
            end else begin
               granted_in = INDEX_W'(head_ff);
               head_in    = rd_data_ff;
               if (used_ff < NIL) begin
                  used_in = used_ff + LW'(1);
               end
            end
         end
         ACT_FREE: begin
            if (null_ff) begin
               status_in = STAT_NULL;
            end else if (index_ext >= eff_ext) begin
               status_in = STAT_RANGE;
            end else begin
               push    = 1'b1;
               head_in = LW'(index_ext);
               if (used_ff != '0) begin
                  used_in = used_ff - LW'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   // link memory write port: rebuild sweep or push
   always_comb begin
      mem_we = 1'b0;
      mem_wa = sweep_ff[IW-1:0];
      mem_wd = (sweep_ff == '0) ? NIL : sweep_ff - LW'(1);
      if (cmd.sweep_step) begin
         mem_we = 1'b1;
      end else if (cmd.commit && push) begin
         mem_we = 1'b1;
         mem_wa = index_ext[IW-1:0];
         mem_wd = head_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (cmd.accept) begin
         rd_data_ff <= mem[head_ff[IW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_size_ff <= POOL_SIZE_RESET;
         head_ff      <= NIL;
         used_ff      <= '0;
         sweep_ff     <= '0;
      end else begin
         if (cmd.csr_write) begin
            pool_size_ff <= csr_pool_size;
         end
         if (cmd.sweep_start) begin
            sweep_ff <= '0;
         end else if (cmd.sweep_step) begin
            sweep_ff <= sweep_ff + LW'(1);
         end
         if (cmd.sweep_finish) begin
            head_ff <= (eff == '0) ? NIL : eff - LW'(1);
            used_ff <= '0;
         end else if (cmd.commit) begin
            head_ff <= head_in;
            used_ff <= used_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         action_ff <= req_action;
         index_ff  <= req_chunk_index;
         null_ff   <= req_is_null;
      end
      if (cmd.commit) begin
         status_ff  <= status_in;
         granted_ff <= granted_in;
         in_use_ff  <= COUNT_W'(used_in);
      end
   end

   assign rsp_status        = status_ff;
   assign rsp_granted_index = granted_ff;
   assign rsp_in_use        = in_use_ff;

endmodule

@@ hdl/fcpa_checker.sv @@
// ----------------------------------------------------------------------------
// fcpa_checker
// port-level checks for the fixed chunk pool allocator
// ----------------------------------------------------------------------------
module fcpa_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [fcpa_pkg::STATUS_W-1:0] rsp_status,
   input logic [fcpa_pkg::INDEX_W-1:0]  rsp_granted_index,
   input logic [fcpa_pkg::COUNT_W-1:0]  rsp_in_use,
   input logic                          csr_ready
);
   import fcpa_pkg::*;

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_granted_index) && $stable(rsp_in_use))
      else $error("rsp changed while stalled");

   // only a successful grant carries an index
   a_grant_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STAT_OK |-> rsp_granted_index == '0)
      else $error("granted index set on failed request");

   // one request at a time
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready && !csr_ready)
      else $error("request taken while busy");

   // reset starts the list rebuild with no result pending
   a_reset_busy: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_ready && !csr_ready)
      else $error("not busy after reset");

endmodule

bind fixed_chunk_pool_allocator fcpa_checker u_fcpa_checker (.*);

@@ bench/tb_fixed_chunk_pool_allocator.sv @@
// ----------------------------------------------------------------------------
// tb_fixed_chunk_pool_allocator
// self-checking bench for the fixed chunk pool allocator: a free list tracker
// predicts status, granted index and in-use count for every request transfer
// and checks each result transfer in order. directed requests cover the edge
// cases (empty pool, null free, range errors, double free, count saturation,
// zero and oversized chunk counts), then random phases run with sender idling,
// receiver stalls and a long receiver hold-off under several chunk counts.
// ----------------------------------------------------------------------------
module tb_fixed_chunk_pool_allocator;
   import fcpa_pkg::*;

   localparam int POOL_DEPTH = 1024;
   localparam int CYCLE_LIMIT = 800000;
   localparam int PHASE_ITEMS = 115;
   localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [INDEX_W-1:0]  granted;
      logic [COUNT_W-1:0]  in_use;
   } pool_result_type;

   class free_list_tracker;
      logic [COUNT_W-1:0] pool_size;
      logic [COUNT_W-1:0] link_mem [POOL_DEPTH];
      logic [COUNT_W-1:0] head;
      logic [COUNT_W-1:0] used;
      logic [INDEX_W-1:0] held [$];
      pool_result_type    pending_results [$];
      int                 failures;

      function new();
         pool_size = POOL_SIZE_RESET;
         failures = 0;
         rebuild();
      endfunction

      function int eff_count();
         return (pool_size > POOL_DEPTH) ? POOL_DEPTH : int'(pool_size);
      endfunction

      // chunk 0 at the bottom, count-1 on top
      function void rebuild();
         logic [COUNT_W-1:0] top;
         top = COUNT_W'(POOL_DEPTH);
         for (int i = 0; i < POOL_DEPTH; i++) begin
            if (i < eff_count()) begin
               link_mem[i] = top;
               top = COUNT_W'(i);
            end else begin
               link_mem[i] = COUNT_W'(POOL_DEPTH);
            end
         end
         head = top;
         used = '0;
         held.delete();
      endfunction

      function void write_pool_size(logic [COUNT_W-1:0] value);
         pool_size = value;
         rebuild();
      endfunction

      function void note_request(logic [ACTION_W-1:0] action, logic [INDEX_W-1:0] idx,
                                 logic is_null);
         pool_result_type r;
         bit              found;
         r.status = STAT_OK;
         r.granted = '0;
         found = 1'b0;
         case (action)
            ACT_ALLOC: begin
               if (head >= POOL_DEPTH) begin
                  r.status = STAT_EMPTY;
               end else begin
                  r.granted = head[INDEX_W-1:0];
                  held.push_back(head[INDEX_W-1:0]);
                  head = link_mem[head];
                  if (used < POOL_DEPTH) used++;
               end
            end
            ACT_FREE: begin
               if (is_null) begin
                  r.status = STAT_NULL;
               end else if (idx >= eff_count()) begin
                  r.status = STAT_RANGE;
               end else begin
                  link_mem[idx] = head;
                  head = {1'b0, idx};
                  if (used > 0) used--;
                  for (int i = 0; i < held.size() && !found; i++) begin
                     if (held[i] == idx) begin
                        held.delete(i);
                        found = 1'b1;
                     end
                  end
               end
            end
            ACT_FREE_ALL: begin
               rebuild();
            end
            default: begin
            end
         endcase
         r.in_use = used;
         pending_results.push_back(r);
      endfunction

      function void check_result(logic [STATUS_W-1:0] status, logic [INDEX_W-1:0] granted,
                                 logic [COUNT_W-1:0] in_use);
         pool_result_type e;
         if (pending_results.size() == 0) begin
            $error("result transfer with no request outstanding");
            failures++;
            return;
         end
         e = pending_results.pop_front();
         if (status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, status);
            failures++;
         end
         if (granted !== e.granted) begin
            $error("granted_index: expected %0d, got %0d", e.granted, granted);
            failures++;
         end
         if (in_use !== e.in_use) begin
            $error("in_use: expected %0d, got %0d", e.in_use, in_use);
            failures++;
         end
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [ACTION_W-1:0] req_action = ACT_ALLOC;
   logic [INDEX_W-1:0]  req_chunk_index = '0;
   logic                req_is_null = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [INDEX_W-1:0]  rsp_granted_index;
   logic [COUNT_W-1:0]  rsp_in_use;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [COUNT_W-1:0]  csr_pool_size = '0;

   free_list_tracker tracker = new();
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_off_cycles = 0;
   int cycle_count = 0;

   fixed_chunk_pool_allocator #(
      .MAX_CHUNKS(POOL_DEPTH)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_action(req_action),
      .req_chunk_index(req_chunk_index),
      .req_is_null(req_is_null),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_granted_index(rsp_granted_index),
      .rsp_in_use(rsp_in_use),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_pool_size(csr_pool_size)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // result side: check each transfer, then decide the next ready
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         tracker.check_result(rsp_status, rsp_granted_index, rsp_in_use);
      if (hold_off_cycles > 0) begin
         rsp_ready <= 1'b0;
         hold_off_cycles <= hold_off_cycles - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic issue_request(input logic [ACTION_W-1:0] action,
                                input logic [INDEX_W-1:0] idx, input logic is_null);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= action;
      req_chunk_index <= idx;
      req_is_null <= is_null;
      do @(posedge clock); while (!req_ready);
      tracker.note_request(action, idx, is_null);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_pool_size(input logic [COUNT_W-1:0] value);
      drain_results();
      csr_valid <= 1'b1;
      csr_pool_size <= value;
      do @(posedge clock); while (!csr_ready);
      tracker.write_pool_size(value);
      csr_valid <= 1'b0;
      csr_pool_size <= COUNT_W'($urandom_range(2047));
   endtask

   task automatic random_request();
      int                  pick;
      int                  top;
      logic [ACTION_W-1:0] action;
      logic [INDEX_W-1:0]  idx;
      logic                is_null;
      pick = $urandom_range(99);
      idx = INDEX_W'($urandom_range(POOL_DEPTH - 1));
      is_null = 1'($urandom_range(1));
      action = ACT_ALLOC;
      if (pick < 45 || (pick < 80 && tracker.held.size() == 0)) begin
         action = ACT_ALLOC;
      end else if (pick < 80) begin
         // well-formed: give back a chunk that is out
         action = ACT_FREE;
         idx = tracker.held[$urandom_range(tracker.held.size() - 1)];
         is_null = 1'b0;
      end else if (pick < 86) begin
         action = ACT_FREE;
         is_null = 1'b0;
      end else if (pick < 91) begin
         action = ACT_FREE;
         is_null = 1'b1;
      end else if (pick < 94) begin
         action = ACT_SPARE;
      end else if (pick < 96) begin
         action = ACT_FREE_ALL;
      end else begin
         // in range, likely a double free
         action = ACT_FREE;
         is_null = 1'b0;
         top = tracker.eff_count();
         idx = INDEX_W'($urandom_range(top > 0 ? top - 1 : 0));
      end
      issue_request(action, idx, is_null);
   endtask

   int phase_counts [8] = '{8, 1024, 37, 2047, 3, 300, 1, 600};

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: default pool of 1024
      issue_request(ACT_ALLOC, 10'd0, 1'b0);
      issue_request(ACT_ALLOC, 10'h3ff, 1'b1);
      issue_request(ACT_FREE, 10'd1023, 1'b0);
      issue_request(ACT_FREE, 10'd1023, 1'b0);
      issue_request(ACT_ALLOC, 10'd0, 1'b0);
      issue_request(ACT_ALLOC, 10'd0, 1'b0);
      issue_request(ACT_FREE, 10'd5, 1'b1);
      issue_request(ACT_FREE, 10'h3ff, 1'b1);
      issue_request(ACT_SPARE, 10'h3ff, 1'b1);
      issue_request(ACT_FREE_ALL, 10'd0, 1'b0);
      issue_request(ACT_FREE, 10'd0, 1'b0);
      issue_request(ACT_FREE, 10'd1023, 1'b0);

      // empty pool
      write_pool_size(11'd0);
      issue_request(ACT_ALLOC, 10'd0, 1'b0);
      issue_request(ACT_FREE, 10'd0, 1'b0);
      issue_request(ACT_FREE_ALL, 10'd0, 1'b0);

      // single chunk, then a double free that loops the list onto itself
      write_pool_size(11'd1);
      issue_request(ACT_ALLOC, 10'd0, 1'b0);
      issue_request(ACT_ALLOC, 10'd0, 1'b0);
      issue_request(ACT_FREE, 10'd1, 1'b0);
      issue_request(ACT_FREE, 10'd0, 1'b0);
      issue_request(ACT_FREE, 10'd0, 1'b0);
      for (int i = 0; i < 8; i++)
         issue_request(ACT_ALLOC, 10'd0, 1'b0);

      // oversized count clamps to the pool depth
      write_pool_size(11'h7ff);
      issue_request(ACT_FREE, 10'd1023, 1'b0);
      issue_request(ACT_ALLOC, 10'd0, 1'b0);

      write_pool_size(11'd5);
      issue_request(ACT_FREE, 10'd5, 1'b0);
      issue_request(ACT_FREE, 10'd1023, 1'b0);
      issue_request(ACT_ALLOC, 10'd0, 1'b0);

      // random phases across counts and idling modes
      for (int p = 0; p < 8; p++) begin
         write_pool_size(COUNT_W'(phase_counts[p]));
         case (p % 4)
            0: begin
               send_idle_pct = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 67;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               recv_stall_pct = 67;
            end
            default: begin
               send_idle_pct = 6;
               recv_stall_pct = 6;
            end
         endcase
         if (p == 4) begin
            send_idle_pct = 0;
            hold_off_cycles = 400;
         end
         for (int i = 0; i < PHASE_ITEMS; i++)
            random_request();
      end

      drain_results();
      repeat (50) @(posedge clock);
      if (tracker.failures == 0 && tracker.pending_results.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end
endmodule

@@ sim.f @@
hdl/fcpa_pkg.sv
hdl/fcpa_ctrl.sv
hdl/fcpa_dpath.sv
hdl/fixed_chunk_pool_allocator.sv
hdl/fcpa_checker.sv
bench/tb_fixed_chunk_pool_allocator.sv
